// File: rtl/pcs_pkg.sv
// ============================================================================
// pcs_pkg: types and constants for the pair compatibility score block.
// Holds the item structs and the fixed widths of the datapath.
// ============================================================================
package pcs_pkg;

    localparam int COORD_W    = 32;
    localparam int THR_W      = 31;
    localparam int SUM_W      = 66;
    localparam int ROOT_W     = 35;
    localparam int SQRT_STEPS = 35;
    localparam int SCORE_BITS = 16;
    localparam int SCORE_W    = SCORE_BITS + 1;
    localparam int PROD_W     = 2 * THR_W;

    localparam logic [THR_W-1:0] THR_RESET = 31'd6554;

    // One input item: two correspondences, four points.
    typedef struct packed {
        logic signed [COORD_W-1:0] src_i_x;
        logic signed [COORD_W-1:0] src_i_y;
        logic signed [COORD_W-1:0] src_i_z;
        logic signed [COORD_W-1:0] src_j_x;
        logic signed [COORD_W-1:0] src_j_y;
        logic signed [COORD_W-1:0] src_j_z;
        logic signed [COORD_W-1:0] tgt_i_x;
        logic signed [COORD_W-1:0] tgt_i_y;
        logic signed [COORD_W-1:0] tgt_i_z;
        logic signed [COORD_W-1:0] tgt_j_x;
        logic signed [COORD_W-1:0] tgt_j_y;
        logic signed [COORD_W-1:0] tgt_j_z;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               compatible;
    } out_item_t;

endpackage

// File: rtl/pair_compatibility_score_top.sv
// ============================================================================
// pair_compatibility_score_top: spatial compatibility score of a point pair.
// Computes both distances by pipelined square roots, then the score by a
// pipelined restoring divider.
// ============================================================================
//  Channel   Ports                          Moves
//  input     s_valid, s_ready, s_item       one pair of correspondences
//  result    m_valid, m_ready, m_item       score and compatible flag
//  config    cfg_wr_en, cfg_wr_data         distance threshold write
//
//  One item enters per cycle unless the result channel stalls; the 35
//  square root stages give one root bit each, the 16 divider stages one
//  score bit each. Reset clears all stage valid bits and loads the default
//  threshold. Each stage holds its item while the next one is full and
//  stalled, so the block keeps taking items until every stage is occupied.
module pair_compatibility_score_top
    import pcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    input  logic               cfg_wr_en,
    input  logic [THR_W-1:0]   cfg_wr_data
);

    localparam int ST_DIFF = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_RT0  = 3;
    localparam int ST_D    = ST_RT0 + SQRT_STEPS;
    localparam int ST_MUL  = ST_D + 1;
    localparam int ST_REM  = ST_MUL + 1;
    localparam int ST_OUT  = ST_REM + SCORE_BITS + 1;
    localparam int NSTG    = ST_OUT + 1;

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;
    logic [THR_W-1:0] thr_reg;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // A stage may load when it is empty or its item moves on.
    assign en[NSTG] = m_ready;
    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_valid : v_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign s_ready = en[0];

    // Coordinate difference magnitudes.
    logic [COORD_W-1:0] dif_reg [0:5];
    logic signed [COORD_W-1:0] ca [0:5];
    logic signed [COORD_W-1:0] cb [0:5];
    assign ca[0] = s_item.src_i_x; assign cb[0] = s_item.src_j_x;
    assign ca[1] = s_item.src_i_y; assign cb[1] = s_item.src_j_y;
    assign ca[2] = s_item.src_i_z; assign cb[2] = s_item.src_j_z;
    assign ca[3] = s_item.tgt_i_x; assign cb[3] = s_item.tgt_j_x;
    assign ca[4] = s_item.tgt_i_y; assign cb[4] = s_item.tgt_j_y;
    assign ca[5] = s_item.tgt_i_z; assign cb[5] = s_item.tgt_j_z;

    logic [63:0] sq_reg [0:5];
    generate
        for (k = 0; k < 6; k++) begin : g_dif
            logic signed [COORD_W:0] dif_next;
            logic [COORD_W:0]        mag_next;
            assign dif_next = {ca[k][COORD_W-1], ca[k]} - {cb[k][COORD_W-1], cb[k]};
            assign mag_next = dif_next[COORD_W] ? 33'(-dif_next) : 33'(dif_next);
            always_ff @(posedge aclk) begin
                if (en[ST_DIFF]) begin
                    dif_reg[k] <= mag_next[COORD_W-1:0];
                end
            end
            // Squares, one 32x32 multiplier each.
            always_ff @(posedge aclk) begin
                if (en[ST_SQ]) begin
                    sq_reg[k] <= 64'(dif_reg[k]) * 64'(dif_reg[k]);
                end
            end
        end
    endgenerate

    // Square root pipeline: lane 0 source distance, lane 1 target distance.
    logic [SUM_W-1:0]  rt_rem_reg  [0:SQRT_STEPS][0:1];
    logic [ROOT_W-1:0] rt_root_reg [0:SQRT_STEPS][0:1];

    genvar g, l;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            // Sum of squares.
            always_ff @(posedge aclk) begin
                if (en[ST_SUM]) begin
                    rt_rem_reg[0][l]  <= SUM_W'(sq_reg[3*l]) + SUM_W'(sq_reg[3*l+1])
                                       + SUM_W'(sq_reg[3*l+2]);
                    rt_root_reg[0][l] <= '0;
                end
            end
            for (g = 0; g < SQRT_STEPS; g++) begin : g_rt
                localparam int B = SQRT_STEPS - 1 - g;
                logic [69:0] trial;
                logic        take;
                assign trial = (70'(rt_root_reg[g][l]) << (B + 1)) | (70'(1) << (2 * B));
                assign take  = 70'(rt_rem_reg[g][l]) >= trial;
                // One root bit per stage.
                always_ff @(posedge aclk) begin
                    if (en[ST_RT0 + g]) begin
                        rt_rem_reg[g+1][l]  <= take ? rt_rem_reg[g][l] - trial[SUM_W-1:0]
                                                    : rt_rem_reg[g][l];
                        rt_root_reg[g+1][l] <= rt_root_reg[g][l]
                                             | (take ? (ROOT_W'(1) << B) : '0);
                    end
                end
            end
        end
    endgenerate

    // Distance difference and early decisions.
    logic [ROOT_W-1:0] d1, d2, d_next;
    logic [THR_W-1:0]  d_reg, t_reg;
    logic              kill_reg, one_reg;
    assign d1     = rt_root_reg[SQRT_STEPS][0];
    assign d2     = rt_root_reg[SQRT_STEPS][1];
    assign d_next = (d1 > d2) ? d1 - d2 : d2 - d1;
    always_ff @(posedge aclk) begin
        if (en[ST_D]) begin
            d_reg    <= d_next[THR_W-1:0];
            t_reg    <= thr_reg;
            kill_reg <= (thr_reg == '0) || (d_next >= ROOT_W'(thr_reg));
            one_reg  <= (d_next == '0);
        end
    end

    // Squares of distance and threshold.
    logic [PROD_W-1:0] dd_reg, tt_reg;
    logic              kill2_reg, one2_reg;
    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            dd_reg    <= PROD_W'(d_reg) * PROD_W'(d_reg);
            tt_reg    <= PROD_W'(t_reg) * PROD_W'(t_reg);
            kill2_reg <= kill_reg;
            one2_reg  <= one_reg;
        end
    end

    // Divider pipeline, one quotient bit per stage.
    logic [PROD_W-1:0]     dv_rem_reg  [0:SCORE_BITS];
    logic [PROD_W-1:0]     dv_tt_reg   [0:SCORE_BITS];
    logic [SCORE_BITS-1:0] dv_q_reg    [0:SCORE_BITS];
    logic                  dv_kill_reg [0:SCORE_BITS];
    logic                  dv_one_reg  [0:SCORE_BITS];

    always_ff @(posedge aclk) begin
        if (en[ST_REM]) begin
            dv_rem_reg[0]  <= kill2_reg ? '0 : tt_reg - dd_reg;
            dv_tt_reg[0]   <= tt_reg;
            dv_q_reg[0]    <= '0;
            dv_kill_reg[0] <= kill2_reg;
            dv_one_reg[0]  <= one2_reg;
        end
    end

    generate
        for (g = 0; g < SCORE_BITS; g++) begin : g_dv
            logic [PROD_W:0] shifted;
            logic            ge;
            assign shifted = {dv_rem_reg[g], 1'b0};
            assign ge      = shifted >= {1'b0, dv_tt_reg[g]};
            always_ff @(posedge aclk) begin
                if (en[ST_REM + 1 + g]) begin
                    dv_rem_reg[g+1]  <= ge ? PROD_W'(shifted - {1'b0, dv_tt_reg[g]})
                                           : shifted[PROD_W-1:0];
                    dv_tt_reg[g+1]   <= dv_tt_reg[g];
                    dv_q_reg[g+1]    <= {dv_q_reg[g][SCORE_BITS-2:0], ge};
                    dv_kill_reg[g+1] <= dv_kill_reg[g];
                    dv_one_reg[g+1]  <= dv_one_reg[g];
                end
            end
        end
    endgenerate

    // Output register.
    logic [SCORE_W-1:0] score_next;
    out_item_t          out_reg;
    always_comb begin
        if (dv_kill_reg[SCORE_BITS]) begin
            score_next = '0;
        end else if (dv_one_reg[SCORE_BITS]) begin
            score_next = SCORE_W'(1) << SCORE_BITS;
        end else begin
            score_next = {1'b0, dv_q_reg[SCORE_BITS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_reg.score      <= score_next;
            out_reg.compatible <= (score_next != '0);
        end
    end

    assign m_valid = v_reg[ST_OUT];
    assign m_item  = out_reg;

endmodule

// File: rtl/pcs_checker.sv
// ============================================================================
// pcs_checker: port-level checks for the pair compatibility score block.
// Watches the result channel and the input backpressure over time.
// ============================================================================
module pcs_checker
    import pcs_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input out_item_t        m_item
);

    // The flag always agrees with the score.
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.compatible == (m_item.score != '0)))
        else $error("compatible flag disagrees with score");

    // The score never exceeds one.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.score <= (SCORE_W'(1) << SCORE_BITS)))
        else $error("score above one");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // An empty output stage never blocks the input.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // No result right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pair_compatibility_score_top pcs_checker u_pcs_checker (.*);
